>>> rtl/dcbp_pkg.sv
// Shared constants, register indexes and the queue status type for the depth-consistent
// back-projection block. No dependencies; all but dcbp_checker use it by scoped name.
`default_nettype none

package dcbp_pkg;

    // parameter defaults
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int DEPTH_BITS_DEF = 16;

    // fixed field widths
    localparam int MAX_HEIGHT = 1024;
    localparam int ROW_W      = 10;
    localparam int PIX_OUT_W  = 10;
    localparam int DEPTH_IN_W = 16;
    localparam int Z_OUT_W    = 16;
    localparam int POINT_W    = 32;
    localparam int DIM_W      = 11;
    localparam int THR_W      = 16;
    localparam int INV_W      = 24;
    localparam int CTR_W      = 14;
    localparam int FRAC_BITS  = 24;
    localparam int MIN_DIM    = 3;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd6;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 11'd480;
    localparam logic [THR_W-1:0] RST_DEPTH_THR    = 16'd20;
    localparam logic [INV_W-1:0] RST_INV_FOCAL    = 24'd36304;
    localparam logic [CTR_W-1:0] RST_CENTER_X     = 14'd5120;
    localparam logic [CTR_W-1:0] RST_CENTER_Y     = 14'd3840;

    // saturation limits of the 32-bit point coordinates
    localparam logic [POINT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [POINT_W-1:0] SAT_NEG = 32'h8000_0000;

    // request queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // register stages of the projection pipeline
    localparam int BACK_STAGES = 5;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

endpackage

`default_nettype wire

>>> rtl/dcbp_front.sv
// Front part: raster counters, two-row line store, 3x3 window and depth-consistency test.
// Uses dcbp_pkg; pushes passing pixels into the request queue under a credit check.
`default_nettype none

module dcbp_front #(
    parameter int MAX_WIDTH  = dcbp_pkg::MAX_WIDTH_DEF,
    parameter int DEPTH_BITS = dcbp_pkg::DEPTH_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rstn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [DEPTH_BITS-1:0]          s_depth,
    input  wire logic                           s_mark,
    input  wire logic                           s_frame_start,
    input  wire logic [$clog2(MAX_WIDTH+1)-1:0] width_eff,
    input  wire logic [dcbp_pkg::DIM_W-1:0]     height_eff,
    input  wire logic [dcbp_pkg::THR_W-1:0]     depth_threshold,
    input  wire dcbp_pkg::q_stat_t              q_stat,
    output logic                                push,
    output logic [$clog2(MAX_WIDTH)-1:0]        push_px,
    output logic [dcbp_pkg::ROW_W-1:0]          push_py,
    output logic [DEPTH_BITS-1:0]               push_z
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = dcbp_pkg::ROW_W;
    localparam int HW    = dcbp_pkg::DIM_W;
    localparam int EW    = DEPTH_BITS + 1;
    localparam int WIN_N = 3;
    localparam int CRW   = dcbp_pkg::QCNT_W + 1;
    localparam int CMW   = (DEPTH_BITS > dcbp_pkg::THR_W) ? DEPTH_BITS : dcbp_pkg::THR_W;

    logic          accept;
    logic [AW-1:0] col_in;
    logic [RW-1:0] row_in;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_inc;
    logic [AW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;

    // stage 1: accepted pixel waiting for its line-store read
    logic          p1_valid_reg;
    logic [AW-1:0] p1_col_reg;
    logic [RW-1:0] p1_row_reg;
    logic [EW-1:0] p1_cur_reg;
    // stage 2: window holds the neighborhood of this pixel's upper-left neighbor
    logic          p2_valid_reg;
    logic [AW-1:0] p2_col_reg;
    logic [RW-1:0] p2_row_reg;

    logic [2*EW-1:0] line_mem [MAX_WIDTH];
    logic [2*EW-1:0] rd_data_reg;
    logic [2*EW-1:0] byp_data_reg;
    logic            byp_hit_reg;
    logic [2*EW-1:0] rd_sel;
    logic [2*EW-1:0] wr_data;
    logic [EW-1:0]   top_px;
    logic [EW-1:0]   mid_px;

    logic [EW-1:0]         win_reg [WIN_N][WIN_N];
    logic [EW-1:0]         centre;
    logic [DEPTH_BITS-1:0] cd;
    logic                  all_near;

    assign accept  = s_valid && s_ready;
    assign s_ready = (CRW'(q_stat.count) + CRW'(p1_valid_reg) + CRW'(p2_valid_reg))
                     < CRW'(dcbp_pkg::QDEPTH);

    // raster position of the incoming pixel and counter advance
    always_comb begin
        col_in = s_frame_start ? '0 : col_cnt_reg;
        row_in = s_frame_start ? '0 : row_cnt_reg;
        if (WW'(col_in) >= width_eff) begin
            col_in = '0;
        end
        if (HW'(row_in) >= height_eff) begin
            row_in = '0;
        end
        col_inc      = WW'(col_in) + WW'(1);
        row_inc      = HW'(row_in) + HW'(1);
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (accept) begin
            if (col_inc >= width_eff) begin
                col_cnt_next = '0;
                row_cnt_next = (row_inc >= height_eff) ? '0 : RW'(row_inc);
            end else begin
                col_cnt_next = AW'(col_inc);
                row_cnt_next = row_in;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            col_cnt_reg  <= col_cnt_next;
            row_cnt_reg  <= row_cnt_next;
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            p1_col_reg <= col_in;
            p1_row_reg <= row_in;
            p1_cur_reg <= {s_mark, s_depth};
        end
        p2_col_reg <= p1_col_reg;
        p2_row_reg <= p1_row_reg;
    end

    // entry = {row two above, row above}; a read that meets the write of the
    // previous pixel at the same column takes the fresh data
    always_ff @(posedge clk) begin
        if (accept) begin
            rd_data_reg  <= line_mem[col_in];
            byp_hit_reg  <= p1_valid_reg && (p1_col_reg == col_in);
            byp_data_reg <= wr_data;
        end
        if (p1_valid_reg) begin
            line_mem[p1_col_reg] <= wr_data;
        end
    end

    assign rd_sel  = byp_hit_reg ? byp_data_reg : rd_data_reg;
    assign top_px  = rd_sel[2*EW-1:EW];
    assign mid_px  = rd_sel[EW-1:0];
    assign wr_data = {mid_px, p1_cur_reg};

    always_ff @(posedge clk) begin
        if (!rstn) begin
            for (int r = 0; r < WIN_N; r++) begin
                for (int c = 0; c < WIN_N; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (p1_valid_reg) begin
            for (int r = 0; r < WIN_N; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top_px;
            win_reg[1][2] <= mid_px;
            win_reg[2][2] <= p1_cur_reg;
        end
    end

    // depth consistency of the window center against all neighbors
    always_comb begin
        logic [DEPTH_BITS-1:0] nd;
        logic [DEPTH_BITS-1:0] diff;
        centre   = win_reg[1][1];
        cd       = centre[DEPTH_BITS-1:0];
        all_near = 1'b1;
        for (int r = 0; r < WIN_N; r++) begin
            for (int c = 0; c < WIN_N; c++) begin
                nd   = win_reg[r][c][DEPTH_BITS-1:0];
                diff = (nd > cd) ? (nd - cd) : (cd - nd);
                if (CMW'(diff) > CMW'(depth_threshold)) begin
                    all_near = 1'b0;
                end
            end
        end
    end

    assign push = p2_valid_reg && (p2_col_reg >= AW'(2)) && (p2_row_reg >= RW'(2))
                  && centre[DEPTH_BITS] && all_near;
    assign push_px = p2_col_reg - AW'(1);
    assign push_py = p2_row_reg - RW'(1);
    assign push_z  = cd;

endmodule

`default_nettype wire

>>> rtl/dcbp_fifo.sv
// Short request queue that decouples the window front from the projection back.
// Uses dcbp_pkg for its depth and status type.
`default_nettype none

module dcbp_fifo #(
    parameter int DATA_W = 8
) (
    input  wire logic              clk,
    input  wire logic              rstn,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic [DATA_W-1:0]      pop_data,
    output dcbp_pkg::q_stat_t      stat
);

    localparam int PW = dcbp_pkg::QPTR_W;
    localparam int CW = dcbp_pkg::QCNT_W;

    logic [DATA_W-1:0] slot_reg [dcbp_pkg::QDEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

    always_ff @(posedge clk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data   = slot_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

>>> rtl/dcbp_axis.sv
// One axis of the pinhole back-projection: offset, two multiply stages, round, saturate.
// Uses dcbp_pkg for field widths; five register stages advancing together on en.
`default_nettype none

module dcbp_axis #(
    parameter int PIX_W      = dcbp_pkg::ROW_W,
    parameter int DEPTH_BITS = dcbp_pkg::DEPTH_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic [PIX_W-1:0]               pixel,
    input  wire logic [dcbp_pkg::CTR_W-1:0]     centre16,
    input  wire logic [DEPTH_BITS-1:0]          z,
    input  wire logic [dcbp_pkg::INV_W-1:0]     inv,
    output logic signed [dcbp_pkg::POINT_W-1:0] point
);

    localparam int MW   = (PIX_W + 4 > dcbp_pkg::CTR_W) ? PIX_W + 4 : dcbp_pkg::CTR_W;
    localparam int TW   = MW + DEPTH_BITS;
    localparam int HALF = dcbp_pkg::INV_W / 2;
    localparam int HIW  = dcbp_pkg::INV_W - HALF;
    localparam int PW   = TW + dcbp_pkg::INV_W;
    localparam int FB   = dcbp_pkg::FRAC_BITS;
    localparam int QW   = PW + 1 - FB;
    localparam int SW   = (QW > dcbp_pkg::POINT_W + 1) ? QW : dcbp_pkg::POINT_W + 1;

    logic [MW-1:0]   p16;
    logic [MW-1:0]   c16;
    logic            neg1_reg, neg2_reg, neg3_reg, neg4_reg;
    logic [MW-1:0]   mag1_reg;
    logic [DEPTH_BITS-1:0] z1_reg;
    logic [TW-1:0]   t2_reg;
    logic [TW+HALF-1:0] pl3_reg;
    logic [TW+HIW-1:0]  ph3_reg;
    logic [PW-1:0]   prod4_reg;
    logic [PW:0]     rnd;
    logic [SW-1:0]   q_ext;
    logic [dcbp_pkg::POINT_W-1:0] sat;
    logic signed [dcbp_pkg::POINT_W-1:0] point_reg;

    assign p16 = MW'({pixel, 4'b0000});
    assign c16 = MW'(centre16);

    // round to nearest, ties away from zero, on the magnitude
    assign rnd   = (PW + 1)'(prod4_reg) + ((PW + 1)'(1) << (FB - 1));
    assign q_ext = SW'(rnd[PW:FB]);

    always_comb begin
        if (neg4_reg) begin
            sat = (q_ext >= SW'(dcbp_pkg::SAT_NEG)) ? dcbp_pkg::SAT_NEG
                                                   : dcbp_pkg::POINT_W'(SW'(0) - q_ext);
        end else begin
            sat = (q_ext > SW'(dcbp_pkg::SAT_POS)) ? dcbp_pkg::SAT_POS
                                                  : dcbp_pkg::POINT_W'(q_ext);
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            neg1_reg  <= p16 < c16;
            mag1_reg  <= (p16 < c16) ? (c16 - p16) : (p16 - c16);
            z1_reg    <= z;
            neg2_reg  <= neg1_reg;
            t2_reg    <= TW'(mag1_reg) * TW'(z1_reg);
            neg3_reg  <= neg2_reg;
            pl3_reg   <= (TW + HALF)'(t2_reg) * (TW + HALF)'(inv[HALF-1:0]);
            ph3_reg   <= (TW + HIW)'(t2_reg) * (TW + HIW)'(inv[dcbp_pkg::INV_W-1:HALF]);
            neg4_reg  <= neg3_reg;
            prod4_reg <= PW'(pl3_reg) + (PW'(ph3_reg) << HALF);
            point_reg <= sat;
        end
    end

    assign point = point_reg;

endmodule

`default_nettype wire

>>> rtl/dcbp_back.sv
// Back part: pops queued pixels and runs both projection axes in a stalling pipeline.
// Uses dcbp_pkg and dcbp_axis; the last stage is the output register.
`default_nettype none

module dcbp_back #(
    parameter int PX_W       = 10,
    parameter int DEPTH_BITS = dcbp_pkg::DEPTH_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rstn,
    input  wire dcbp_pkg::q_stat_t              q_stat,
    output logic                                pop,
    input  wire logic [PX_W-1:0]                item_px,
    input  wire logic [dcbp_pkg::ROW_W-1:0]     item_py,
    input  wire logic [DEPTH_BITS-1:0]          item_z,
    input  wire logic [dcbp_pkg::INV_W-1:0]     inv_focal_x,
    input  wire logic [dcbp_pkg::INV_W-1:0]     inv_focal_y,
    input  wire logic [dcbp_pkg::CTR_W-1:0]     center_x,
    input  wire logic [dcbp_pkg::CTR_W-1:0]     center_y,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [dcbp_pkg::PIX_OUT_W-1:0]      m_pixel_x,
    output logic [dcbp_pkg::PIX_OUT_W-1:0]      m_pixel_y,
    output logic signed [dcbp_pkg::POINT_W-1:0] m_point_x,
    output logic signed [dcbp_pkg::POINT_W-1:0] m_point_y,
    output logic [dcbp_pkg::Z_OUT_W-1:0]        m_point_z
);

    localparam int NS = dcbp_pkg::BACK_STAGES;

    logic                              en;
    logic [NS-1:0]                     vld_reg;
    logic [dcbp_pkg::PIX_OUT_W-1:0]    pix_x_reg [NS];
    logic [dcbp_pkg::PIX_OUT_W-1:0]    pix_y_reg [NS];
    logic [dcbp_pkg::Z_OUT_W-1:0]      z_out_reg [NS];

    // advance everything unless a finished result is held
    assign en  = !vld_reg[NS-1] || m_ready;
    assign pop = en && !q_stat.empty;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], pop};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            pix_x_reg[0] <= dcbp_pkg::PIX_OUT_W'(item_px);
            pix_y_reg[0] <= dcbp_pkg::PIX_OUT_W'(item_py);
            z_out_reg[0] <= dcbp_pkg::Z_OUT_W'(item_z);
            for (int k = 1; k < NS; k++) begin
                pix_x_reg[k] <= pix_x_reg[k-1];
                pix_y_reg[k] <= pix_y_reg[k-1];
                z_out_reg[k] <= z_out_reg[k-1];
            end
        end
    end

    dcbp_axis #(
        .PIX_W      (PX_W),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_axis_x (
        .clk      (clk),
        .en       (en),
        .pixel    (item_px),
        .centre16 (center_x),
        .z        (item_z),
        .inv      (inv_focal_x),
        .point    (m_point_x)
    );

    dcbp_axis #(
        .PIX_W      (dcbp_pkg::ROW_W),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_axis_y (
        .clk      (clk),
        .en       (en),
        .pixel    (item_py),
        .centre16 (center_y),
        .z        (item_z),
        .inv      (inv_focal_y),
        .point    (m_point_y)
    );

    assign m_valid   = vld_reg[NS-1];
    assign m_pixel_x = pix_x_reg[NS-1];
    assign m_pixel_y = pix_y_reg[NS-1];
    assign m_point_z = z_out_reg[NS-1];

endmodule

`default_nettype wire

>>> rtl/depth_consistent_backprojection.sv
// Top level of the depth-consistent back-projection block: configuration registers, front
// (window test), request queue and back (projection). Uses dcbp_pkg and dcbp_front/fifo/back.
//
// Usage:
//  - Input channel s_*: one depth pixel per request in raster order, with its obstacle
//    mark and a frame_start flag on the first pixel of a frame. Taken on s_valid & s_ready.
//  - Result channel m_*: one request per marked interior pixel whose eight neighbors all lie
//    within depth_threshold; column, row, X and Y in 1/16 mm (saturated) and Z in mm.
//    Results leave in raster order, one row and one column behind the input.
//  - Config port: cfg_we writes cfg_wdata to register cfg_idx; write only
//    while no pixel is in flight.
//  - Path: a passing pixel reaches m_valid through the 2 window stages, the queue and
//    the 5 projection stages.
//  - Throughput: one pixel per cycle while s_ready is high. s_ready is high while the 4-entry
//    queue has room for one more pixel beyond those still in the two window stages.
//  - Receiver stall: m_* holds; the projection pipeline freezes, the queue fills, and
//    s_ready drops once the queue credit is used up. Nothing is dropped.
//  - Reset (aresetn low at a clock edge): raster counters to zero, window to zero, queue
//    and pipeline empty, config registers to their defaults. The line store is not
//    cleared; border rows never read stale entries.
`default_nettype none

module depth_consistent_backprojection #(
    parameter int MAX_WIDTH  = dcbp_pkg::MAX_WIDTH_DEF,
    parameter int DEPTH_BITS = dcbp_pkg::DEPTH_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [dcbp_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [dcbp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // pixel input
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [dcbp_pkg::DEPTH_IN_W-1:0] s_depth_mm,
    input  wire logic                            s_in_obstacle,
    input  wire logic                            s_frame_start,
    // point output
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [dcbp_pkg::PIX_OUT_W-1:0]       m_pixel_x,
    output logic [dcbp_pkg::PIX_OUT_W-1:0]       m_pixel_y,
    output logic signed [dcbp_pkg::POINT_W-1:0]  m_point_x,
    output logic signed [dcbp_pkg::POINT_W-1:0]  m_point_y,
    output logic [dcbp_pkg::Z_OUT_W-1:0]         m_point_z
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = dcbp_pkg::DIM_W;
    localparam int LW = (WW > HW) ? WW : HW;
    localparam int RW = dcbp_pkg::ROW_W;
    localparam int QD = AW + RW + DEPTH_BITS;

    // configuration registers
    logic [HW-1:0]                    image_width_reg;
    logic [HW-1:0]                    image_height_reg;
    logic [dcbp_pkg::THR_W-1:0]       depth_thr_reg;
    logic [dcbp_pkg::INV_W-1:0]       inv_focal_x_reg;
    logic [dcbp_pkg::INV_W-1:0]       inv_focal_y_reg;
    logic [dcbp_pkg::CTR_W-1:0]       center_x_reg;
    logic [dcbp_pkg::CTR_W-1:0]       center_y_reg;

    logic [LW-1:0] width_ext;
    logic [WW-1:0] width_eff;
    logic [HW-1:0] height_eff;

    // front to queue
    logic                  push;
    logic [AW-1:0]         push_px;
    logic [RW-1:0]         push_py;
    logic [DEPTH_BITS-1:0] push_z;
    logic [QD-1:0]         pop_data;
    logic                  pop;
    dcbp_pkg::q_stat_t     q_stat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= dcbp_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= dcbp_pkg::RST_IMAGE_HEIGHT;
            depth_thr_reg    <= dcbp_pkg::RST_DEPTH_THR;
            inv_focal_x_reg  <= dcbp_pkg::RST_INV_FOCAL;
            inv_focal_y_reg  <= dcbp_pkg::RST_INV_FOCAL;
            center_x_reg     <= dcbp_pkg::RST_CENTER_X;
            center_y_reg     <= dcbp_pkg::RST_CENTER_Y;
        end else if (cfg_we) begin
            case (cfg_idx)
                dcbp_pkg::REG_IMAGE_WIDTH: begin
                    image_width_reg <= cfg_wdata[HW-1:0];
                end
                dcbp_pkg::REG_IMAGE_HEIGHT: begin
                    image_height_reg <= cfg_wdata[HW-1:0];
                end
                dcbp_pkg::REG_DEPTH_THR: begin
                    depth_thr_reg <= cfg_wdata[dcbp_pkg::THR_W-1:0];
                end
                dcbp_pkg::REG_INV_FOCAL_X: begin
                    inv_focal_x_reg <= cfg_wdata[dcbp_pkg::INV_W-1:0];
                end
                dcbp_pkg::REG_INV_FOCAL_Y: begin
                    inv_focal_y_reg <= cfg_wdata[dcbp_pkg::INV_W-1:0];
                end
                dcbp_pkg::REG_CENTER_X: begin
                    center_x_reg <= cfg_wdata[dcbp_pkg::CTR_W-1:0];
                end
                dcbp_pkg::REG_CENTER_Y: begin
                    center_y_reg <= cfg_wdata[dcbp_pkg::CTR_W-1:0];
                end
                default: begin
                    // unused index: drop the write
                end
            endcase
        end
    end

    // clamp the frame size between MIN_DIM and what the line store and row counter can hold
    always_comb begin
        width_ext = LW'(image_width_reg);
        if (width_ext < LW'(dcbp_pkg::MIN_DIM)) begin
            width_eff = WW'(dcbp_pkg::MIN_DIM);
        end else if (width_ext > LW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(width_ext);
        end
        if (image_height_reg < HW'(dcbp_pkg::MIN_DIM)) begin
            height_eff = HW'(dcbp_pkg::MIN_DIM);
        end else if (image_height_reg > HW'(dcbp_pkg::MAX_HEIGHT)) begin
            height_eff = HW'(dcbp_pkg::MAX_HEIGHT);
        end else begin
            height_eff = image_height_reg;
        end
    end

    dcbp_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_front (
        .clk             (aclk),
        .rstn            (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_depth         (DEPTH_BITS'(s_depth_mm)),
        .s_mark          (s_in_obstacle),
        .s_frame_start   (s_frame_start),
        .width_eff       (width_eff),
        .height_eff      (height_eff),
        .depth_threshold (depth_thr_reg),
        .q_stat          (q_stat),
        .push            (push),
        .push_px         (push_px),
        .push_py         (push_py),
        .push_z          (push_z)
    );

    dcbp_fifo #(
        .DATA_W (QD)
    ) u_fifo (
        .clk       (aclk),
        .rstn      (aresetn),
        .push      (push),
        .push_data ({push_px, push_py, push_z}),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (q_stat)
    );

    dcbp_back #(
        .PX_W       (AW),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_back (
        .clk         (aclk),
        .rstn        (aresetn),
        .q_stat      (q_stat),
        .pop         (pop),
        .item_px     (pop_data[QD-1:RW+DEPTH_BITS]),
        .item_py     (pop_data[RW+DEPTH_BITS-1:DEPTH_BITS]),
        .item_z      (pop_data[DEPTH_BITS-1:0]),
        .inv_focal_x (inv_focal_x_reg),
        .inv_focal_y (inv_focal_y_reg),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_x   (m_pixel_x),
        .m_pixel_y   (m_pixel_y),
        .m_point_x   (m_point_x),
        .m_point_y   (m_point_y),
        .m_point_z   (m_point_z)
    );

endmodule

`default_nettype wire

>>> rtl/dcbp_checker.sv
// Port-level checks for the depth-consistent back-projection block and the bind that
// attaches them to its top level. Uses only the top level's ports.
`default_nettype none

module dcbp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [9:0]  m_pixel_x,
    input wire logic [9:0]  m_pixel_y,
    input wire logic [31:0] m_point_x,
    input wire logic [31:0] m_point_y,
    input wire logic [15:0] m_point_z
);

    // a stalled result holds
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_x) && $stable(m_pixel_y)
            && $stable(m_point_x) && $stable(m_point_y) && $stable(m_point_z))
        else $error("stalled result changed or vanished");

    // the first row never yields a point
    a_no_top_border: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pixel_y != 10'd0)
        else $error("result on the top border row");

    // zero depth projects to the origin
    a_zero_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_point_z == 16'd0 |-> m_point_x == 32'd0 && m_point_y == 32'd0)
        else $error("nonzero lateral position at zero depth");

    // reset empties the output stage
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind depth_consistent_backprojection dcbp_checker u_dcbp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_pixel_x (m_pixel_x),
    .m_pixel_y (m_pixel_y),
    .m_point_x (m_point_x),
    .m_point_y (m_point_y),
    .m_point_z (m_point_z)
);

`default_nettype wire
